/* hdl/tdpt_pkg.sv */
// tdpt_pkg: shared types for the trial-division prime test unit.
// No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} tdpt_state_t;

endpackage

/* hdl/trial_division_prime_test_unit.sv */
// trial_division_prime_test_unit: primality test by trial division.
// Uses tdpt_pkg for the sequencer state type.
//
// Usage:
//   Input channel (in_valid / in_stall / candidate) takes one unsigned word.
//   Output channel (out_valid / out_stall / is_prime) returns one flag per
//   word, in order. A word is moved when valid is high and stall is low.
// Operation:
//   Divisors d = 2, 3, ... are tried while d*d <= candidate. Each trial is a
//   bound check in ST_CHECK followed by a bit-serial restoring division,
//   one candidate bit per cycle; d*d is kept up to date by adding 2d+1.
// Work per word:
//   k divisors are tried per word; the test ends at the first divisor
//   that divides. Worst case for NUM_WIDTH = 16 (large primes): k = 254.
//   A new word is taken only in ST_IDLE, after the last result is loaded.
//   One word is in work at a time; in_stall is high from accept until the
//   result is loaded into the output register.
// Stall / reset:
//   The result sits in an output register while out_stall is high; the next
//   word may be accepted and worked on meanwhile. arst_n clears the sequencer
//   and output valid; no state carries over between words.
`timescale 1ns / 1ps

module trial_division_prime_test_unit #(
	parameter int NUM_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NUM_WIDTH-1:0] candidate,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_prime
);
	import tdpt_pkg::*;

	localparam int SQ_W  = 2 * NUM_WIDTH;
	localparam int CNT_W = $clog2(NUM_WIDTH);

	tdpt_state_t state_q, state_d;

	logic [NUM_WIDTH-1:0] cand_q;      // candidate, held for the whole test
	logic [NUM_WIDTH-1:0] cand_sh_q;   // candidate bits shifted out MSB first
	logic [NUM_WIDTH-1:0] rem_q;       // partial remainder
	logic [NUM_WIDTH-1:0] div_q;       // current trial divisor d
	logic [SQ_W-1:0]      sq_q;        // d*d
	logic [CNT_W-1:0]     cnt_q;       // bits left after the current step
	logic                 res_q;       // result pending in ST_DONE
	logic                 out_valid_q;
	logic                 is_prime_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 too_small;
	logic                 bound_hit;
	logic [NUM_WIDTH:0]   rem_sh;
	logic [NUM_WIDTH:0]   rem_diff;
	logic [NUM_WIDTH-1:0] rem_next;
	logic                 div_last;

	// control strobes
	logic ld_word, ld_div, div_step, next_div, set_res, res_val, ld_out;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign too_small = (cand_q <= NUM_WIDTH'(1));
	assign bound_hit = (sq_q > SQ_W'(cand_q));

	// one step of restoring division
	assign rem_sh   = {rem_q, cand_sh_q[NUM_WIDTH-1]};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign rem_next = rem_diff[NUM_WIDTH] ? rem_sh[NUM_WIDTH-1:0] : rem_diff[NUM_WIDTH-1:0];
	assign div_last = (cnt_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (too_small || bound_hit)
					state_d = ST_DONE;
				else
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					if (rem_next == '0)
						state_d = ST_DONE;
					else
						state_d = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		ld_word  = 1'b0;
		ld_div   = 1'b0;
		div_step = 1'b0;
		next_div = 1'b0;
		set_res  = 1'b0;
		res_val  = 1'b0;
		ld_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ld_word  = in_valid;
			end
			ST_CHECK: begin
				if (too_small) begin
					set_res = 1'b1;
					res_val = 1'b0;
				end else if (bound_hit) begin
					set_res = 1'b1;
					res_val = 1'b1;
				end else begin
					ld_div = 1'b1;
				end
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (div_last) begin
					if (rem_next == '0) begin
						set_res = 1'b1;
						res_val = 1'b0;
					end else begin
						next_div = 1'b1;
					end
				end
			end
			ST_DONE: begin
				ld_out = out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_word) begin
			cand_q <= candidate;
			div_q  <= NUM_WIDTH'(2);
			sq_q   <= SQ_W'(4);
		end
		if (ld_div) begin
			cand_sh_q <= cand_q;
			rem_q     <= '0;
			cnt_q     <= CNT_W'(NUM_WIDTH - 1);
		end
		if (div_step) begin
			cand_sh_q <= {cand_sh_q[NUM_WIDTH-2:0], 1'b0};
			rem_q     <= rem_next;
			cnt_q     <= cnt_q - CNT_W'(1);
		end
		// (d+1)^2 = d^2 + 2d + 1
		if (next_div) begin
			div_q <= div_q + NUM_WIDTH'(1);
			sq_q  <= sq_q + SQ_W'({div_q, 1'b1});
		end
		if (set_res)
			res_q <= res_val;
		if (ld_out)
			is_prime_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	// division runs only while the bound d*d <= candidate holds
	a_bound_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (sq_q <= SQ_W'(cand_q)))
		else $error("trial division past the square bound");

	// partial remainder always below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("partial remainder out of range");

	// a prime verdict never for 0 or 1
	a_prime_ge2: assert property (@(posedge clk) disable iff (!arst_n)
		(set_res && res_val) |-> (cand_q >= NUM_WIDTH'(2)))
		else $error("prime flag for candidate below two");

	// a finished result reaches the output register on the next edge
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> (out_valid && (is_prime == $past(res_q))))
		else $error("result not loaded into output register");

endmodule
